### rtl/avcs_pkg.sv
// ----------------------------------------------------------------------------
// avcs_pkg
// Shared types, codes and helpers of the ADC voltage/current scaler.
// ----------------------------------------------------------------------------
package avcs_pkg;

   localparam int CODE_W  = 31;
   localparam int PROD_W  = 47;
   localparam int NUM_W   = 48;
   localparam int QUOT_W  = 32;
   localparam int ITER_W  = 6;

   // result status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_RANGE  = 2'd1;
   localparam logic [1:0] ST_CONFIG = 2'd2;

   // register indexes
   localparam logic [2:0] CSR_REF   = 3'd0;
   localparam logic [2:0] CSR_BITS  = 3'd1;
   localparam logic [2:0] CSR_MUL   = 3'd2;
   localparam logic [2:0] CSR_DIV   = 3'd3;
   localparam logic [2:0] CSR_VOFF  = 3'd4;
   localparam logic [2:0] CSR_GAIN  = 3'd5;
   localparam logic [2:0] CSR_COFF  = 3'd6;

   localparam logic [15:0] MA_PER_A = 16'd1000;

   typedef enum logic [1:0] {
      KIND_CFG_ERR,
      KIND_RANGE,
      KIND_CALC
   } kind_type;

   typedef struct packed {
      logic [15:0]        ref_mv;
      logic [4:0]         adc_bits;
      logic [15:0]        mul;
      logic [15:0]        div;
      logic signed [31:0] voff;
      logic [15:0]        gain;
      logic signed [31:0] coff;
   } cfg_type;

   typedef struct packed {
      kind_type           kind;
      logic               crange;
      logic [CODE_W-1:0]  vcode;
      logic [CODE_W-1:0]  ccode;
   } entry_type;

   typedef struct packed {
      logic [CODE_W-1:0]  rem0;
      logic [QUOT_W-1:0]  low;
      logic [CODE_W-1:0]  den;
      logic [ITER_W-1:0]  iters;
   } div_req_type;

   // full scale 2^bits - 1
   function automatic logic [CODE_W-1:0] full_scale(input logic [4:0] bits);
      logic [31:0] one_sh;
      one_sh = 32'd1 << bits;
      return CODE_W'(one_sh - 32'd1);
   endfunction

endpackage

### rtl/avcs_front.sv
// ----------------------------------------------------------------------------
// avcs_front
// Takes transactions in and sorts them: config error, range error or compute.
// ----------------------------------------------------------------------------
module avcs_front (
   input  logic                          start,
   input  logic                          full,
   input  logic [avcs_pkg::CODE_W-1:0]   voltage_code,
   input  logic [avcs_pkg::CODE_W-1:0]   current_code,
   input  avcs_pkg::cfg_type             cfg,
   output logic                          push,
   output avcs_pkg::entry_type           entry
);

   logic [avcs_pkg::CODE_W-1:0] fs;
   logic                        cfg_bad;

   always_comb begin
      fs      = avcs_pkg::full_scale(cfg.adc_bits);
      cfg_bad = (cfg.ref_mv == '0) || (cfg.adc_bits == '0) || (cfg.mul == '0) ||
                (cfg.div == '0) || (cfg.gain == '0);
      push         = start && !full;
      entry.vcode  = voltage_code;
      entry.ccode  = current_code;
      entry.crange = current_code > fs;
      if (cfg_bad) begin
         entry.kind = avcs_pkg::KIND_CFG_ERR;
      end else if (voltage_code > fs) begin
         entry.kind = avcs_pkg::KIND_RANGE;
      end else begin
         entry.kind = avcs_pkg::KIND_CALC;
      end
   end

endmodule

### rtl/avcs_queue.sv
// ----------------------------------------------------------------------------
// avcs_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module avcs_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  avcs_pkg::entry_type  push_entry,
   input  logic                 pop,
   output avcs_pkg::entry_type  head,
   output logic                 full,
   output logic                 empty
);

   avcs_pkg::entry_type mem_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;

   always_comb begin
      full      = count_ff == 2'd2;
      empty     = count_ff == 2'd0;
      head      = mem_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### rtl/avcs_div.sv
// ----------------------------------------------------------------------------
// avcs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module avcs_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  avcs_pkg::div_req_type         req,
   output logic                          done,
   output logic [avcs_pkg::QUOT_W-1:0]   quot
);

   logic [avcs_pkg::CODE_W-1:0]  rem_ff, rem_in;
   logic [avcs_pkg::QUOT_W-1:0]  low_ff, low_in;
   logic [avcs_pkg::QUOT_W-1:0]  quot_ff, quot_in;
   logic [avcs_pkg::CODE_W-1:0]  den_ff;
   logic [avcs_pkg::ITER_W-1:0]  cnt_ff;
   logic                         run_ff;
   logic                         done_ff;
   logic [avcs_pkg::CODE_W:0]    shifted;
   logic [avcs_pkg::CODE_W:0]    trial;

   always_comb begin
      shifted = {rem_ff, low_ff[avcs_pkg::QUOT_W-1]};
      trial   = shifted - {1'b0, den_ff};
      low_in  = {low_ff[avcs_pkg::QUOT_W-2:0], 1'b0};
      if (shifted >= {1'b0, den_ff}) begin
         rem_in  = trial[avcs_pkg::CODE_W-1:0];
         quot_in = {quot_ff[avcs_pkg::QUOT_W-2:0], 1'b1};
      end else begin
         rem_in  = shifted[avcs_pkg::CODE_W-1:0];
         quot_in = {quot_ff[avcs_pkg::QUOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= req.iters;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == avcs_pkg::ITER_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         rem_ff  <= req.rem0;
         low_ff  <= req.low;
         den_ff  <= req.den;
         quot_ff <= '0;
      end else if (run_ff) begin
         rem_ff  <= rem_in;
         low_ff  <= low_in;
         quot_ff <= quot_in;
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

### rtl/avcs_back.sv
// ----------------------------------------------------------------------------
// avcs_back
// Sequences up to four rounded divisions of a transaction and issues its result.
// ----------------------------------------------------------------------------
module avcs_back (
   input  logic                          clock,
   input  logic                          reset,
   input  avcs_pkg::cfg_type             cfg,
   input  logic                          empty,
   input  avcs_pkg::entry_type           head,
   output logic                          pop,
   output logic                          rsp_strobe,
   output logic                          rsp_valid_res,
   output logic [1:0]                    rsp_status,
   output logic [31:0]                   rsp_voltage_mv,
   output logic signed [31:0]            rsp_current_ma
);

   typedef enum logic [1:0] {S_IDLE, S_PREP, S_LOAD, S_WAIT} state_type;
   typedef enum logic [1:0] {OP_VMV, OP_VOLT, OP_CMV, OP_CURR} op_type;

   state_type                       state_ff;
   op_type                          op_ff;
   logic [avcs_pkg::CODE_W-1:0]     vcode_ff, ccode_ff;
   logic                            crange_ff;
   logic [15:0]                     mv_ff;
   logic [31:0]                     volt_ff;
   logic [avcs_pkg::PROD_W-1:0]     prod_ff, prod_in;
   logic                            div_start_ff;
   avcs_pkg::div_req_type           div_req_ff, div_req_in;
   logic                            rsp_strobe_ff, rsp_valid_ff;
   logic [1:0]                      rsp_status_ff;
   logic [31:0]                     rsp_volt_ff;
   logic signed [31:0]              rsp_curr_ff;

   logic                            div_done;
   logic [avcs_pkg::QUOT_W-1:0]     div_quot;
   logic [avcs_pkg::CODE_W-1:0]     fs;
   logic [avcs_pkg::CODE_W-1:0]     mul_a;
   logic [15:0]                     mul_b;
   logic [avcs_pkg::CODE_W-1:0]     den;
   logic [avcs_pkg::NUM_W-1:0]      num;
   logic signed [34:0]              vsum;
   logic signed [33:0]              csum;

   avcs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .req   (div_req_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      fs = avcs_pkg::full_scale(cfg.adc_bits);
      unique case (op_ff)
         OP_VMV: begin
            mul_a = vcode_ff;
            mul_b = cfg.ref_mv;
            den   = fs;
         end
         OP_VOLT: begin
            mul_a = avcs_pkg::CODE_W'(mv_ff);
            mul_b = cfg.mul;
            den   = avcs_pkg::CODE_W'(cfg.div);
         end
         OP_CMV: begin
            mul_a = ccode_ff;
            mul_b = cfg.ref_mv;
            den   = fs;
         end
         default: begin
            mul_a = avcs_pkg::CODE_W'(mv_ff);
            mul_b = avcs_pkg::MA_PER_A;
            den   = avcs_pkg::CODE_W'(cfg.gain);
         end
      endcase
      prod_in = mul_a * mul_b;
      // numerator with half the divisor added for round-to-nearest
      num = {1'b0, prod_ff} + avcs_pkg::NUM_W'(den >> 1);
      div_req_in.den = den;
      // start the remainder at num >> iters; quotient fits in iters bits
      unique case (op_ff)
         OP_VOLT: begin
            div_req_in.rem0  = avcs_pkg::CODE_W'(num[47:32]);
            div_req_in.low   = num[31:0];
            div_req_in.iters = avcs_pkg::ITER_W'(32);
         end
         OP_CURR: begin
            div_req_in.rem0  = avcs_pkg::CODE_W'(num[47:26]);
            div_req_in.low   = {num[25:0], 6'b0};
            div_req_in.iters = avcs_pkg::ITER_W'(26);
         end
         default: begin
            div_req_in.rem0  = num[47:17];
            div_req_in.low   = {num[16:0], 15'b0};
            div_req_in.iters = avcs_pkg::ITER_W'(17);
         end
      endcase
      vsum = $signed({3'b0, div_quot}) + 35'(cfg.voff);
      csum = $signed({2'b0, div_quot}) + 34'(cfg.coff);
      pop  = (state_ff == S_IDLE) && !empty;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         op_ff         <= OP_VMV;
         div_start_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         div_start_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (!empty) begin
                  vcode_ff  <= head.vcode;
                  ccode_ff  <= head.ccode;
                  crange_ff <= head.crange;
                  op_ff     <= OP_VMV;
                  unique case (head.kind)
                     avcs_pkg::KIND_CFG_ERR: begin
                        rsp_strobe_ff <= 1'b1;
                        rsp_valid_ff  <= 1'b0;
                        rsp_status_ff <= avcs_pkg::ST_CONFIG;
                        rsp_volt_ff   <= '0;
                        rsp_curr_ff   <= '0;
                     end
                     avcs_pkg::KIND_RANGE: begin
                        rsp_strobe_ff <= 1'b1;
                        rsp_valid_ff  <= 1'b0;
                        rsp_status_ff <= avcs_pkg::ST_RANGE;
                        rsp_volt_ff   <= '0;
                        rsp_curr_ff   <= '0;
                     end
                     default: begin
                        state_ff <= S_PREP;
                     end
                  endcase
               end
            end
            S_PREP: begin
               prod_ff  <= prod_in;
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               div_req_ff   <= div_req_in;
               div_start_ff <= 1'b1;
               state_ff     <= S_WAIT;
            end
            S_WAIT: begin
               if (div_done) begin
                  unique case (op_ff)
                     OP_VMV: begin
                        mv_ff    <= div_quot[15:0];
                        op_ff    <= OP_VOLT;
                        state_ff <= S_PREP;
                     end
                     OP_VOLT: begin
                        if ((vsum[34:32] != 3'b000) || crange_ff) begin
                           rsp_strobe_ff <= 1'b1;
                           rsp_valid_ff  <= 1'b0;
                           rsp_status_ff <= avcs_pkg::ST_RANGE;
                           rsp_volt_ff   <= '0;
                           rsp_curr_ff   <= '0;
                           state_ff      <= S_IDLE;
                        end else begin
                           volt_ff  <= vsum[31:0];
                           op_ff    <= OP_CMV;
                           state_ff <= S_PREP;
                        end
                     end
                     OP_CMV: begin
                        mv_ff    <= div_quot[15:0];
                        op_ff    <= OP_CURR;
                        state_ff <= S_PREP;
                     end
                     default: begin
                        rsp_strobe_ff <= 1'b1;
                        state_ff      <= S_IDLE;
                        if ((csum[33:31] == 3'b000) || (csum[33:31] == 3'b111)) begin
                           rsp_valid_ff  <= 1'b1;
                           rsp_status_ff <= avcs_pkg::ST_OK;
                           rsp_volt_ff   <= volt_ff;
                           rsp_curr_ff   <= csum[31:0];
                        end else begin
                           rsp_valid_ff  <= 1'b0;
                           rsp_status_ff <= avcs_pkg::ST_RANGE;
                           rsp_volt_ff   <= '0;
                           rsp_curr_ff   <= '0;
                        end
                     end
                  endcase
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_valid_res  = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_voltage_mv = rsp_volt_ff;
   assign rsp_current_ma = rsp_curr_ff;

endmodule

### rtl/adc_voltage_current_scaler_core.sv
// ----------------------------------------------------------------------------
// adc_voltage_current_scaler_core
// Converts ADC voltage/current code pairs to scaled millivolts and milliamps.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; every transaction
// yields exactly one result, shown for one cycle with rsp_strobe, in order.
// The receiver cannot stall, so results are never held back. A two-entry
// queue sits between the input classifier and the compute sequencer, so busy
// only rises when two transactions are waiting. Transactions failing the
// config check or with a voltage code above full scale complete at one per
// cycle while the back end is idle. Computed transactions hold the back end
// for up to four rounded divisions on one shared bit-serial divider (17, 32,
// 17 and 26 quotient bits), each made of a multiply, a divider load, the
// divider start, the iterations and the hand-back, after the pop from the
// queue; a voltage out of range or a current code above full scale ends the
// transaction after the second division. The user must write registers through
// the csr port only while no transaction is in flight; the block does not enforce it.
module adc_voltage_current_scaler_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [30:0]         req_voltage_code,
   input  logic [30:0]         req_current_code,
   output logic                rsp_strobe,
   output logic                rsp_valid_res,
   output logic [1:0]          rsp_status,
   output logic [31:0]         rsp_voltage_mv,
   output logic signed [31:0]  rsp_current_ma,
   input  logic                csr_write_enable,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_data
);

   avcs_pkg::cfg_type    cfg_ff;
   avcs_pkg::entry_type  push_entry, head;
   logic                 push, pop, full, empty;

   // configuration registers; out-of-list indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ref_mv   <= 16'd3300;
         cfg_ff.adc_bits <= 5'd12;
         cfg_ff.mul      <= 16'd1;
         cfg_ff.div      <= 16'd1;
         cfg_ff.voff     <= '0;
         cfg_ff.gain     <= 16'd1;
         cfg_ff.coff     <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            avcs_pkg::CSR_REF:  cfg_ff.ref_mv   <= csr_data[15:0];
            avcs_pkg::CSR_BITS: cfg_ff.adc_bits <= csr_data[4:0];
            avcs_pkg::CSR_MUL:  cfg_ff.mul      <= csr_data[15:0];
            avcs_pkg::CSR_DIV:  cfg_ff.div      <= csr_data[15:0];
            avcs_pkg::CSR_VOFF: cfg_ff.voff     <= csr_data;
            avcs_pkg::CSR_GAIN: cfg_ff.gain     <= csr_data[15:0];
            avcs_pkg::CSR_COFF: cfg_ff.coff     <= csr_data;
            default: ;
         endcase
      end
   end

   avcs_front u_front (
      .start        (start),
      .full         (full),
      .voltage_code (req_voltage_code),
      .current_code (req_current_code),
      .cfg          (cfg_ff),
      .push         (push),
      .entry        (push_entry)
   );

   avcs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .full       (full),
      .empty      (empty)
   );

   avcs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .empty          (empty),
      .head           (head),
      .pop            (pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_valid_res  (rsp_valid_res),
      .rsp_status     (rsp_status),
      .rsp_voltage_mv (rsp_voltage_mv),
      .rsp_current_ma (rsp_current_ma)
   );

   assign busy = full;

`ifndef NO_ASSERTIONS
   a_valid_iff_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_valid_res == (rsp_status == avcs_pkg::ST_OK)))
      else $error("valid_res disagrees with status");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != avcs_pkg::ST_OK)) |->
      ((rsp_voltage_mv == '0) && (rsp_current_ma == '0)))
      else $error("failed result carries nonzero data");

   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(full && empty))
      else $error("queue full and empty at once");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");
`endif

endmodule

### dv/tb_adc_voltage_current_scaler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adc_voltage_current_scaler_core
// Sends ADC code pairs through the scaler and checks each result, field by
// field and in order, against a typed-in result or a local model of the
// conversion. The run starts with a short table of directed steps, then goes
// through a series of mostly random register settings with bursty random traffic.
// ----------------------------------------------------------------------------
module tb_adc_voltage_current_scaler_core;
   import avcs_pkg::*;

   localparam logic [2:0] CSR_NONE = 3'd7;  // past the last register, ignored
   localparam int N_PHASES = 12;
   localparam int N_RANDOM = 1900;

   typedef enum logic [1:0] {
      ROW_WRITE,      // register write, block drained first
      ROW_CHECKED,    // transaction with a typed-in result
      ROW_PREDICTED   // transaction checked against the model
   } row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      logic [2:0]         index;
      logic [31:0]        data;
      logic [30:0]        vcode;
      logic [30:0]        ccode;
      logic               valid;
      logic [1:0]         status;
      logic [31:0]        volt;
      logic [31:0]        curr;
   } table_row_type;

   typedef struct packed {
      logic               valid;
      logic [1:0]         status;
      logic [31:0]        volt;
      logic signed [31:0] curr;
   } reading_type;

   typedef struct {
      logic [15:0]        ref_mv;
      logic [4:0]         bits;
      logic [15:0]        mul;
      logic [15:0]        div;
      logic signed [31:0] voff;
      logic [15:0]        gain;
      logic signed [31:0] coff;
   } scaler_regs_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [30:0] req_voltage_code = '0;
   logic [30:0] req_current_code = '0;
   logic        rsp_strobe;
   logic        rsp_valid_res;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_voltage_mv;
   logic signed [31:0] rsp_current_ma;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   scaler_regs_type regs;
   reading_type     expected_readings[$];
   int              mismatches = 0;

   adc_voltage_current_scaler_core dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_voltage_code (req_voltage_code),
      .req_current_code (req_current_code),
      .rsp_strobe       (rsp_strobe),
      .rsp_valid_res    (rsp_valid_res),
      .rsp_status       (rsp_status),
      .rsp_voltage_mv   (rsp_voltage_mv),
      .rsp_current_ma   (rsp_current_ma),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Directed steps. Reset config: 3300 mV reference, 12 bits (full scale 4095).
   table_row_type steps[$] = '{
      '{ROW_CHECKED,   CSR_NONE, 32'd0, 31'd0,    31'd0,    1'b1, ST_OK,    32'd0,    32'd0},
      '{ROW_CHECKED,   CSR_NONE, 32'd0, 31'd4095, 31'd4095, 1'b1, ST_OK,    32'd3300,
        32'd3300000},
      // voltage code just above full scale, then the current code
      '{ROW_CHECKED,   CSR_NONE, 32'd0, 31'd4096, 31'd0,    1'b0, ST_RANGE, 32'd0,    32'd0},
      '{ROW_CHECKED,   CSR_NONE, 32'd0, 31'd0,    31'd4096, 1'b0, ST_RANGE, 32'd0,    32'd0},
      '{ROW_CHECKED,   CSR_NONE, 32'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0, ST_RANGE,
        32'd0, 32'd0},
      '{ROW_PREDICTED, CSR_NONE, 32'd0, 31'd2048, 31'd1,    1'b0, ST_OK,    32'd0,    32'd0},
      // write past the register list must change nothing
      '{ROW_WRITE,     CSR_NONE, 32'd0, 31'd0,    31'd0,    1'b0, ST_OK,    32'd0,    32'd0},
      '{ROW_CHECKED,   CSR_NONE, 32'd0, 31'd4095, 31'd0,    1'b1, ST_OK,    32'd3300, 32'd0},
      // negative voltage
      '{ROW_WRITE,     CSR_VOFF, 32'hFFFF_FFFF, 31'd0, 31'd0, 1'b0, ST_OK,  32'd0,    32'd0},
      '{ROW_CHECKED,   CSR_NONE, 32'd0, 31'd0,    31'd0,    1'b0, ST_RANGE, 32'd0,    32'd0},
      '{ROW_PREDICTED, CSR_NONE, 32'd0, 31'd2,    31'd0,    1'b0, ST_OK,    32'd0,    32'd0},
      // voltage above 2^32-1
      '{ROW_WRITE,     CSR_VOFF, 32'h7FFF_FFFF, 31'd0, 31'd0, 1'b0, ST_OK,  32'd0,    32'd0},
      '{ROW_WRITE,     CSR_REF,  32'd65535, 31'd0, 31'd0,  1'b0, ST_OK,    32'd0,    32'd0},
      '{ROW_WRITE,     CSR_MUL,  32'd65535, 31'd0, 31'd0,  1'b0, ST_OK,    32'd0,    32'd0},
      '{ROW_CHECKED,   CSR_NONE, 32'd0, 31'd4095, 31'd0,    1'b0, ST_RANGE, 32'd0,    32'd0},
      '{ROW_WRITE,     CSR_VOFF, 32'd0, 31'd0,    31'd0,    1'b0, ST_OK,    32'd0,    32'd0},
      '{ROW_CHECKED,   CSR_NONE, 32'd0, 31'd4095, 31'd0,    1'b1, ST_OK,    32'hFFFE_0001,
        32'd0},
      // current above int32, then exactly int32 min
      '{ROW_WRITE,     CSR_COFF, 32'h7FFF_FFFF, 31'd0, 31'd0, 1'b0, ST_OK,  32'd0,    32'd0},
      '{ROW_PREDICTED, CSR_NONE, 32'd0, 31'd0,    31'd1,    1'b0, ST_OK,    32'd0,    32'd0},
      '{ROW_WRITE,     CSR_COFF, 32'h8000_0000, 31'd0, 31'd0, 1'b0, ST_OK,  32'd0,    32'd0},
      '{ROW_CHECKED,   CSR_NONE, 32'd0, 31'd0,    31'd0,    1'b1, ST_OK,    32'd0,
        32'h8000_0000},
      '{ROW_WRITE,     CSR_BITS, 32'd31, 31'd0,   31'd0,    1'b0, ST_OK,    32'd0,    32'd0},
      '{ROW_PREDICTED, CSR_NONE, 32'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0, ST_OK,
        32'd0, 32'd0},
      '{ROW_WRITE,     CSR_BITS, 32'd1, 31'd0,    31'd0,    1'b0, ST_OK,    32'd0,    32'd0},
      '{ROW_WRITE,     CSR_GAIN, 32'd65535, 31'd0, 31'd0,  1'b0, ST_OK,    32'd0,    32'd0},
      '{ROW_WRITE,     CSR_DIV,  32'd65535, 31'd0, 31'd0,  1'b0, ST_OK,    32'd0,    32'd0},
      '{ROW_PREDICTED, CSR_NONE, 32'd0, 31'd1,    31'd1,    1'b0, ST_OK,    32'd0,    32'd0},
      '{ROW_CHECKED,   CSR_NONE, 32'd0, 31'd2,    31'd0,    1'b0, ST_RANGE, 32'd0,    32'd0},
      // each zero register is a config error, checked before the codes
      '{ROW_WRITE,     CSR_REF,  32'd0, 31'd0,    31'd0,    1'b0, ST_OK,    32'd0,    32'd0},
      '{ROW_CHECKED,   CSR_NONE, 32'd0, 31'd5,    31'd0,    1'b0, ST_CONFIG, 32'd0,   32'd0},
      '{ROW_WRITE,     CSR_REF,  32'd3300, 31'd0, 31'd0,    1'b0, ST_OK,    32'd0,    32'd0},
      '{ROW_WRITE,     CSR_BITS, 32'd0, 31'd0,    31'd0,    1'b0, ST_OK,    32'd0,    32'd0},
      '{ROW_CHECKED,   CSR_NONE, 32'd0, 31'd0,    31'd0,    1'b0, ST_CONFIG, 32'd0,   32'd0},
      '{ROW_WRITE,     CSR_BITS, 32'd12, 31'd0,   31'd0,    1'b0, ST_OK,    32'd0,    32'd0},
      '{ROW_WRITE,     CSR_MUL,  32'd0, 31'd0,    31'd0,    1'b0, ST_OK,    32'd0,    32'd0},
      '{ROW_CHECKED,   CSR_NONE, 32'd0, 31'd1,    31'd1,    1'b0, ST_CONFIG, 32'd0,   32'd0},
      '{ROW_WRITE,     CSR_MUL,  32'd1, 31'd0,    31'd0,    1'b0, ST_OK,    32'd0,    32'd0},
      '{ROW_WRITE,     CSR_DIV,  32'd0, 31'd0,    31'd0,    1'b0, ST_OK,    32'd0,    32'd0},
      '{ROW_CHECKED,   CSR_NONE, 32'd0, 31'd1,    31'd1,    1'b0, ST_CONFIG, 32'd0,   32'd0},
      '{ROW_WRITE,     CSR_DIV,  32'd1, 31'd0,    31'd0,    1'b0, ST_OK,    32'd0,    32'd0},
      '{ROW_WRITE,     CSR_GAIN, 32'd0, 31'd0,    31'd0,    1'b0, ST_OK,    32'd0,    32'd0},
      '{ROW_CHECKED,   CSR_NONE, 32'd0, 31'd1,    31'd1,    1'b0, ST_CONFIG, 32'd0,   32'd0},
      '{ROW_WRITE,     CSR_GAIN, 32'd1, 31'd0,    31'd0,    1'b0, ST_OK,    32'd0,    32'd0},
      '{ROW_PREDICTED, CSR_NONE, 32'd0, 31'd1,    31'd1,    1'b0, ST_OK,    32'd0,    32'd0}
   };

   function automatic longint unsigned rounded_quotient(longint unsigned num,
                                                        longint unsigned den);
      return (num + den / 2) / den;
   endfunction

   // Expected result of one code pair under the current register shadow.
   function automatic reading_type scale_reading(logic [30:0] vcode, logic [30:0] ccode);
      longint unsigned fs, vmv, cmv;
      longint          volt, curr;
      reading_type     r;
      r = '0;
      r.status = ST_OK;
      if (regs.ref_mv == 0 || regs.bits == 0 || regs.mul == 0 || regs.div == 0 ||
          regs.gain == 0) begin
         r.status = ST_CONFIG;
         return r;
      end
      fs = (64'd1 << regs.bits) - 64'd1;
      if (vcode > fs) begin
         r.status = ST_RANGE;
         return r;
      end
      vmv  = rounded_quotient(longint'(vcode) * regs.ref_mv, fs);
      volt = longint'(rounded_quotient(vmv * regs.mul, regs.div)) + longint'(regs.voff);
      // voltage failure skips the current channel entirely
      if (volt < 0 || volt > 64'sh0_FFFF_FFFF || ccode > fs) begin
         r.status = ST_RANGE;
         return r;
      end
      cmv  = rounded_quotient(longint'(ccode) * regs.ref_mv, fs);
      curr = longint'(rounded_quotient(cmv * 1000, regs.gain)) + longint'(regs.coff);
      if (curr < -64'sd2147483648 || curr > 64'sd2147483647) begin
         r.status = ST_RANGE;
         return r;
      end
      r.valid = 1'b1;
      r.volt  = volt[31:0];
      r.curr  = curr[31:0];
      return r;
   endfunction

   // Leaves the write enable high; the caller lowers it after the last write.
   task automatic put_reg(logic [2:0] index, logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_data         <= data;
      @(posedge clock);
      case (index)
         CSR_REF:  regs.ref_mv = data[15:0];
         CSR_BITS: regs.bits   = data[4:0];
         CSR_MUL:  regs.mul    = data[15:0];
         CSR_DIV:  regs.div    = data[15:0];
         CSR_VOFF: regs.voff   = signed'(data);
         CSR_GAIN: regs.gain   = data[15:0];
         CSR_COFF: regs.coff   = signed'(data);
         default: ;
      endcase
   endtask

   // Start stays high on return so back-to-back transactions need no gap.
   task automatic send_pair(logic [30:0] vcode, logic [30:0] ccode, bit typed_in,
                            reading_type typed);
      start            <= 1'b1;
      req_voltage_code <= vcode;
      req_current_code <= ccode;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_readings.push_back(typed_in ? typed : scale_reading(vcode, ccode));
   endtask

   task automatic pause(int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Every transaction yields a result, so an empty queue means idle.
   task automatic drain;
      start <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_u16(bit allow_zero);
      case ($urandom_range(9))
         0:       return allow_zero && $urandom_range(3) == 0 ? 16'd0 : 16'd65535;
         1:       return 16'd1;
         default: return 16'($urandom_range(65535, 1));
      endcase
   endfunction

   function automatic logic [31:0] pick_offset;
      case ($urandom_range(7))
         0:       return $urandom();
         1:       return 32'h8000_0000;
         2:       return 32'h7FFF_FFFF;
         default: return 32'($signed($urandom_range(4000)) - 2000);
      endcase
   endfunction

   task automatic program_phase(int phase);
      logic [31:0] vals [7];
      case (phase)
         0: vals = '{32'd65535, 32'd31, 32'd65535, 32'd1, 32'd0, 32'd1, 32'd0};
         1: vals = '{32'd1, 32'd1, 32'd1, 32'd65535, 32'd0, 32'd65535, 32'd0};
         default: begin
            vals[CSR_REF]  = pick_u16(1'b1);
            vals[CSR_BITS] = $urandom_range(40) == 0 ? 32'd0 : $urandom_range(31, 1);
            vals[CSR_MUL]  = pick_u16(1'b1);
            vals[CSR_DIV]  = pick_u16(1'b1);
            vals[CSR_VOFF] = pick_offset();
            vals[CSR_GAIN] = pick_u16(1'b1);
            vals[CSR_COFF] = pick_offset();
         end
      endcase
      // a third of the time put the widest code range on the table
      if (phase > 1 && $urandom_range(2) == 0)
         vals[CSR_BITS] = 32'd31;
      for (int i = 0; i < 7; i++)
         put_reg(3'(i), vals[i]);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [30:0] pick_code;
      longint unsigned fs;
      fs = (64'd1 << regs.bits) - 64'd1;
      if (regs.bits == 0 || fs >= 64'h7FFF_FFFF)
         return 31'($urandom());
      // mostly in range, sometimes over full scale
      if ($urandom_range(9) != 0)
         return 31'($urandom_range(32'(fs), 0));
      return 31'($urandom_range(32'h7FFF_FFFF, 32'(fs) + 1));
   endfunction

   // -------------------------------------------------------------------------
   // Result checker: each strobe is compared with the oldest expectation.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_strobe) begin
         if (expected_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: valid=%0d status=%0d volt=%0d curr=%0d",
                        rsp_valid_res, rsp_status, rsp_voltage_mv, rsp_current_ma);
         end else begin
            want = expected_readings.pop_front();
            if (rsp_valid_res !== want.valid || rsp_status !== want.status ||
                rsp_voltage_mv !== want.volt || rsp_current_ma !== want.curr) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"result %0t: exp valid=%0d status=%0d volt=%0d curr=%0d,",
                            " got %0d %0d %0d %0d"},
                           $time, want.valid, want.status, want.volt, want.curr,
                           rsp_valid_res, rsp_status, rsp_voltage_mv, rsp_current_ma);
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      reading_type typed;
      int          sent, burst, waited;
      regs = '{16'd3300, 5'd12, 16'd1, 16'd1, 32'sd0, 16'd1, 32'sd0};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (steps[i]) begin
         if (steps[i].kind == ROW_WRITE) begin
            drain();
            put_reg(steps[i].index, steps[i].data);
         end else begin
            csr_write_enable <= 1'b0;
            typed = '{steps[i].valid, steps[i].status, steps[i].volt, steps[i].curr};
            send_pair(steps[i].vcode, steps[i].ccode, steps[i].kind == ROW_CHECKED, typed);
         end
      end
      csr_write_enable <= 1'b0;
      drain();

      // random phases; draining before each phase also covers the idle hold-off
      for (int phase = 0; phase < N_PHASES; phase++) begin
         program_phase(phase);
         sent = 0;
         while (sent < N_RANDOM / N_PHASES) begin
            burst = $urandom_range(20, 1);
            for (int k = 0; k < burst; k++) begin
               send_pair(pick_code(), pick_code(), 1'b0, '0);
               sent++;
            end
            // some phases run gap-free
            if (phase % 4 != 3)
               pause($urandom_range(3) == 0 ? $urandom_range(120) : $urandom_range(6));
         end
         drain();
      end

      waited = 0;
      while (expected_readings.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      if (expected_readings.size() != 0) begin
         $display("adc_voltage_current_scaler_core: mismatch");
         $finish;
      end else begin
         repeat (200) @(posedge clock);
         if (mismatches == 0) begin
            $display("adc_voltage_current_scaler_core: match");
         end else begin
            $display("adc_voltage_current_scaler_core: mismatch");
         end
         $finish;
      end
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #20ms;
      $display("adc_voltage_current_scaler_core: mismatch");
      $finish;
   end

endmodule

### sim.f
rtl/avcs_pkg.sv
rtl/avcs_front.sv
rtl/avcs_queue.sv
rtl/avcs_div.sv
rtl/avcs_back.sv
rtl/adc_voltage_current_scaler_core.sv
dv/tb_adc_voltage_current_scaler_core.sv
